// File: hdl/psm_pkg.sv
// Shared constants and widths for the polyline simplification block.
// Used by the mask core (the top level); no dependencies.
package psm_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_BITS = 24;

   localparam int IDX_BITS = $clog2(MAX_POINTS);
   localparam int CNT_BITS = $clog2(MAX_POINTS + 1);

   localparam int EPS_BITS  = 24;
   localparam int E2_BITS   = 2 * EPS_BITS;
   localparam int E2_HALF   = EPS_BITS;
   localparam int CSR_BITS  = 32;
   localparam int ADDR_BITS = 3;

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int HALF_BITS = COORD_BITS + 1;
   localparam int CM_BITS   = 2 * HALF_BITS;
   localparam int L2_BITS   = 2 * COORD_BITS + 2;
   localparam int L2_HALF   = L2_BITS / 2;
   localparam int OP_BITS   = (COORD_BITS + 2 > EPS_BITS + 2) ? COORD_BITS + 2 : EPS_BITS + 2;
   localparam int PROD_BITS = 2 * OP_BITS;
   localparam int ACC_BITS  = (4 * COORD_BITS + 4 > E2_BITS + L2_BITS + 1) ?
                              4 * COORD_BITS + 4 : E2_BITS + L2_BITS + 1;
   localparam int SH_BITS   = 8;

   localparam int PT_WIDTH  = 3 * COORD_BITS;
   localparam int SEG_WIDTH = 2 * IDX_BITS;

   localparam logic CSR_EPSILON    = 1'b0;
   localparam logic CSR_THREE_DIMS = 1'b1;

endpackage

// File: hdl/psm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module psm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/polyline_simplify_mask_core.sv
// Polyline keep-mask core: point loading, iterative segment-stack simplification, mask output.
// Depends on psm_pkg and psm_ram (point store, segment stack and keep bits).
//
// Input channel (req_): one point per item, accepted when req_valid is high and req_stall low.
// Points are stored in order, one per cycle, while the core is idle. A point that arrives with
// MAX_POINTS points already stored is dropped and the overflow flag is raised for the polyline.
// The item that carries req_last_point starts the simplification pass; req_stall is high from
// then until the last mask item has been loaded into the output register.
// Each segment popped from the stack is first set up (epsilon squared, chord length squared and
// their product as threshold; a degenerate chord skips the product), then each interior point is
// measured: every product goes through one shared signed multiplier followed by an accumulate
// state. A pass runs longest when every split peels off a single point; then the mask items
// follow, one per cycle while the receiver takes them.
// Result channel (rsp_): one item per stored point in index order, from a single output
// register; rsp_last marks the final one. While rsp_stall is high the register holds and the
// pass waits; the next polyline may be loaded while the final item still waits.
// Configuration (csr_): APB-style, epsilon at address 0, three_dims at address 4; write only
// while idle. Synchronous reset clears counters, flags and the sequencer; no clearing pass,
// each keep bit is written as its point is loaded: set for the first point, else cleared.
module polyline_simplify_mask_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [psm_pkg::COORD_BITS-1:0] req_coord_x,
   input  logic signed [psm_pkg::COORD_BITS-1:0] req_coord_y,
   input  logic signed [psm_pkg::COORD_BITS-1:0] req_coord_z,
   input  logic                                  req_last_point,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [psm_pkg::IDX_BITS-1:0]          rsp_point_index,
   output logic                                  rsp_keep,
   output logic                                  rsp_overflow,
   output logic                                  rsp_last,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [psm_pkg::ADDR_BITS-1:0]         csr_paddr,
   input  logic [psm_pkg::CSR_BITS-1:0]          csr_pwdata,
   output logic [psm_pkg::CSR_BITS-1:0]          csr_prdata,
   output logic                                  csr_pready
);
   import psm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT, ST_POP, ST_SEG, ST_LDS, ST_LDT, ST_SMUL, ST_SACC,
      ST_RDP, ST_LDP, ST_PMUL, ST_PACC, ST_CMP, ST_TEST, ST_PUSH2, ST_EMIT
   } state_type;

   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;

   state_type               state_ff;
   logic [EPS_BITS-1:0]     eps_ff;
   logic                    dims_ff;
   logic [CNT_BITS-1:0]     count_ff;
   logic [CNT_BITS-1:0]     n_ff;
   logic [CNT_BITS-1:0]     sp_ff;
   logic                    ovf_ff;
   logic [IDX_BITS-1:0]     si_ff, li_ff, i_ff, idx_ff, em_ff;
   coord_type               s_ff [3];
   diff_type                v1_ff [3];
   diff_type                v2_ff [3];
   logic [E2_BITS-1:0]      e2_ff;
   logic [L2_BITS-1:0]      l2_ff;
   logic [ACC_BITS-1:0]     thr_ff, m_ff, best_ff;
   logic signed [PROD_BITS-1:0] cr_ff, prod_ff;
   logic [2:0]              sop_ff, sub_ff;
   logic [1:0]              comp_ff;
   logic                    rsp_valid_ff, rsp_keep_ff, rsp_ovf_ff, rsp_last_ff;
   logic [IDX_BITS-1:0]     rsp_idx_ff;

   logic                    pt_wr;
   logic [IDX_BITS-1:0]     pt_rd_addr;
   logic [PT_WIDTH-1:0]     pt_wr_data, pt_rd_data;
   logic                    stk_wr;
   logic [IDX_BITS-1:0]     stk_wr_addr, stk_rd_addr;
   logic [SEG_WIDTH-1:0]    stk_wr_data, stk_rd_data;
   logic                    kp_wr, kp_wr_data, kp_rd_data;
   logic [IDX_BITS-1:0]     kp_wr_addr, kp_rd_addr;

   coord_type               rd_c [3];
   logic                    degen;
   logic                    accept;
   logic                    room;
   logic                    csr_wr;
   logic                    emit_load;
   logic [IDX_BITS-1:0]     last_idx;
   logic [IDX_BITS-1:0]     seg_si, seg_li;
   logic [PROD_BITS-1:0]    crm_full;
   logic [CM_BITS-1:0]      crm;
   logic [HALF_BITS-1:0]    cm_lo, cm_hi;
   logic signed [OP_BITS-1:0] op_a, op_b;
   logic [SH_BITS-1:0]      acc_sh;
   logic [ACC_BITS-1:0]     acc_add;
   logic [1:0]              ca, cb, k1;

   psm_ram #(.WIDTH(PT_WIDTH), .DEPTH(MAX_POINTS)) u_points (
      .clock   (clock),
      .wr_en   (pt_wr),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (pt_wr_data),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   psm_ram #(.WIDTH(SEG_WIDTH), .DEPTH(MAX_POINTS)) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   psm_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_keep (
      .clock   (clock),
      .wr_en   (kp_wr),
      .wr_addr (kp_wr_addr),
      .wr_data (kp_wr_data),
      .rd_addr (kp_rd_addr),
      .rd_data (kp_rd_data)
   );

   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign room       = count_ff < CNT_BITS'(MAX_POINTS);
   assign pt_wr      = accept && room;
   assign pt_wr_data = {req_coord_x, req_coord_y, req_coord_z};
   assign last_idx   = IDX_BITS'(n_ff - CNT_BITS'(1));
   assign seg_si     = stk_rd_data[SEG_WIDTH-1:IDX_BITS];
   assign seg_li     = stk_rd_data[IDX_BITS-1:0];
   assign stk_rd_addr = IDX_BITS'(sp_ff - CNT_BITS'(1));
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign emit_load  = !rsp_valid_ff || !rsp_stall;

   assign rd_c[0] = pt_rd_data[3*COORD_BITS-1:2*COORD_BITS];
   assign rd_c[1] = pt_rd_data[2*COORD_BITS-1:COORD_BITS];
   assign rd_c[2] = dims_ff ? pt_rd_data[COORD_BITS-1:0] : '0;

   assign degen = (v1_ff[0] == '0) && (v1_ff[1] == '0) && (v1_ff[2] == '0);

   assign crm_full = cr_ff[PROD_BITS-1] ? PROD_BITS'(-cr_ff) : PROD_BITS'(cr_ff);
   assign crm      = crm_full[CM_BITS-1:0];
   assign cm_lo    = crm[HALF_BITS-1:0];
   assign cm_hi    = crm[CM_BITS-1:HALF_BITS];
   assign acc_add  = ACC_BITS'($unsigned(prod_ff)) << acc_sh;

   always_comb begin
      pt_rd_addr = i_ff;
      stk_wr      = 1'b0;
      stk_wr_addr = sp_ff[IDX_BITS-1:0];
      stk_wr_data = {si_ff, idx_ff};
      unique case (state_ff)
         ST_SEG: pt_rd_addr = seg_si;
         ST_LDS: pt_rd_addr = li_ff;
         ST_INIT: begin
            stk_wr      = 1'b1;
            stk_wr_addr = '0;
            stk_wr_data = {IDX_BITS'(0), last_idx};
         end
         ST_TEST: stk_wr = (best_ff > thr_ff) && (sp_ff < CNT_BITS'(MAX_POINTS));
         ST_PUSH2: begin
            stk_wr      = sp_ff < CNT_BITS'(MAX_POINTS);
            stk_wr_data = {idx_ff, li_ff};
         end
         default: ;
      endcase
   end

   always_comb begin
      kp_wr      = 1'b0;
      kp_wr_addr = idx_ff;
      kp_wr_data = 1'b1;
      kp_rd_addr = em_ff;
      unique case (state_ff)
         ST_IDLE: begin
            kp_wr      = pt_wr;
            kp_wr_addr = count_ff[IDX_BITS-1:0];
            kp_wr_data = (count_ff == '0);
         end
         ST_INIT: begin
            kp_wr      = 1'b1;
            kp_wr_addr = last_idx;
         end
         ST_TEST: kp_wr = best_ff > thr_ff;
         ST_EMIT: begin
            if (emit_load && (em_ff != last_idx)) begin
               kp_rd_addr = em_ff + IDX_BITS'(1);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (comp_ff)
         2'd0:    begin ca = 2'd1; cb = 2'd2; end
         2'd1:    begin ca = 2'd2; cb = 2'd0; end
         default: begin ca = 2'd0; cb = 2'd1; end
      endcase
      k1     = 2'(sop_ff - 3'd1);
      op_a   = '0;
      op_b   = '0;
      acc_sh = '0;
      if (state_ff == ST_SMUL || state_ff == ST_SACC) begin
         unique case (sop_ff)
            3'd0: begin op_a = OP_BITS'(eps_ff); op_b = OP_BITS'(eps_ff); end
            3'd1, 3'd2, 3'd3: begin op_a = OP_BITS'(v1_ff[k1]); op_b = OP_BITS'(v1_ff[k1]); end
            3'd4: begin
               op_a = OP_BITS'(e2_ff[E2_HALF-1:0]); op_b = OP_BITS'(l2_ff[L2_HALF-1:0]);
            end
            3'd5: begin
               op_a = OP_BITS'(e2_ff[E2_HALF-1:0]); op_b = OP_BITS'(l2_ff[L2_BITS-1:L2_HALF]);
               acc_sh = SH_BITS'(L2_HALF);
            end
            3'd6: begin
               op_a = OP_BITS'(e2_ff[E2_BITS-1:E2_HALF]); op_b = OP_BITS'(l2_ff[L2_HALF-1:0]);
               acc_sh = SH_BITS'(E2_HALF);
            end
            default: begin
               op_a = OP_BITS'(e2_ff[E2_BITS-1:E2_HALF]);
               op_b = OP_BITS'(l2_ff[L2_BITS-1:L2_HALF]);
               acc_sh = SH_BITS'(E2_HALF + L2_HALF);
            end
         endcase
      end else if (degen) begin
         op_a = OP_BITS'(v2_ff[sub_ff[1:0]]);
         op_b = OP_BITS'(v2_ff[sub_ff[1:0]]);
      end else begin
         unique case (sub_ff)
            3'd0: begin op_a = OP_BITS'(v1_ff[ca]); op_b = OP_BITS'(v2_ff[cb]); end
            3'd1: begin op_a = OP_BITS'(v1_ff[cb]); op_b = OP_BITS'(v2_ff[ca]); end
            3'd2: begin op_a = OP_BITS'(cm_lo); op_b = OP_BITS'(cm_lo); end
            3'd3: begin
               op_a = OP_BITS'(cm_hi); op_b = OP_BITS'(cm_lo); acc_sh = SH_BITS'(HALF_BITS + 1);
            end
            default: begin
               op_a = OP_BITS'(cm_hi); op_b = OP_BITS'(cm_hi); acc_sh = SH_BITS'(2 * HALF_BITS);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eps_ff       <= '0;
         dims_ff      <= 1'b0;
         count_ff     <= '0;
         n_ff         <= '0;
         sp_ff        <= '0;
         ovf_ff       <= 1'b0;
         em_ff        <= '0;
         sop_ff       <= '0;
         sub_ff       <= '0;
         comp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (csr_paddr[2])
               CSR_EPSILON:    eps_ff  <= csr_pwdata[EPS_BITS-1:0];
               CSR_THREE_DIMS: dims_ff <= csr_pwdata[0];
            endcase
         end
         if ((state_ff != ST_EMIT) && rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         prod_ff <= op_a * op_b;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (room) begin
                     count_ff <= count_ff + CNT_BITS'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_last_point) begin
                     n_ff     <= room ? count_ff + CNT_BITS'(1) : count_ff;
                     state_ff <= ST_INIT;
                  end
               end
            end
            ST_INIT: begin
               sp_ff    <= CNT_BITS'(1);
               em_ff    <= '0;
               state_ff <= ST_POP;
            end
            ST_POP: begin
               if (sp_ff == '0) begin
                  state_ff <= ST_EMIT;
               end else begin
                  sp_ff    <= sp_ff - CNT_BITS'(1);
                  state_ff <= ST_SEG;
               end
            end
            ST_SEG: begin
               si_ff <= seg_si;
               li_ff <= seg_li;
               if (CNT_BITS'(seg_li) < CNT_BITS'(seg_si) + CNT_BITS'(2)) begin
                  state_ff <= ST_POP;
               end else begin
                  state_ff <= ST_LDS;
               end
            end
            ST_LDS: begin
               s_ff     <= rd_c;
               state_ff <= ST_LDT;
            end
            ST_LDT: begin
               for (int k = 0; k < 3; k++) begin
                  v1_ff[k] <= DIFF_BITS'(rd_c[k]) - DIFF_BITS'(s_ff[k]);
               end
               l2_ff    <= '0;
               thr_ff   <= '0;
               best_ff  <= '0;
               idx_ff   <= si_ff;
               i_ff     <= si_ff + IDX_BITS'(1);
               sop_ff   <= '0;
               state_ff <= ST_SMUL;
            end
            ST_SMUL: state_ff <= ST_SACC;
            ST_SACC: begin
               unique case (sop_ff)
                  3'd0:             e2_ff  <= prod_ff[E2_BITS-1:0];
                  3'd1, 3'd2, 3'd3: l2_ff  <= l2_ff + prod_ff[L2_BITS-1:0];
                  default:          thr_ff <= thr_ff + acc_add;
               endcase
               if (sop_ff == 3'd3 && degen) begin
                  thr_ff   <= ACC_BITS'(e2_ff);
                  state_ff <= ST_RDP;
               end else if (sop_ff == 3'd7) begin
                  state_ff <= ST_RDP;
               end else begin
                  sop_ff   <= sop_ff + 3'd1;
                  state_ff <= ST_SMUL;
               end
            end
            ST_RDP: state_ff <= ST_LDP;
            ST_LDP: begin
               for (int k = 0; k < 3; k++) begin
                  v2_ff[k] <= DIFF_BITS'(s_ff[k]) - DIFF_BITS'(rd_c[k]);
               end
               m_ff     <= '0;
               sub_ff   <= '0;
               comp_ff  <= '0;
               state_ff <= ST_PMUL;
            end
            ST_PMUL: state_ff <= ST_PACC;
            ST_PACC: begin
               if (degen) begin
                  m_ff <= m_ff + acc_add;
                  if (sub_ff == 3'd2) begin
                     state_ff <= ST_CMP;
                  end else begin
                     sub_ff   <= sub_ff + 3'd1;
                     state_ff <= ST_PMUL;
                  end
               end else begin
                  unique case (sub_ff)
                     3'd0:    cr_ff <= prod_ff;
                     3'd1:    cr_ff <= cr_ff - prod_ff;
                     default: m_ff  <= m_ff + acc_add;
                  endcase
                  if (sub_ff == 3'd4) begin
                     sub_ff <= '0;
                     if (comp_ff == 2'd2) begin
                        state_ff <= ST_CMP;
                     end else begin
                        comp_ff  <= comp_ff + 2'd1;
                        state_ff <= ST_PMUL;
                     end
                  end else begin
                     sub_ff   <= sub_ff + 3'd1;
                     state_ff <= ST_PMUL;
                  end
               end
            end
            ST_CMP: begin
               if (m_ff > best_ff) begin
                  best_ff <= m_ff;
                  idx_ff  <= i_ff;
               end
               if (CNT_BITS'(i_ff) + CNT_BITS'(1) == CNT_BITS'(li_ff)) begin
                  state_ff <= ST_TEST;
               end else begin
                  i_ff     <= i_ff + IDX_BITS'(1);
                  state_ff <= ST_RDP;
               end
            end
            ST_TEST: begin
               if (best_ff > thr_ff) begin
                  if (stk_wr) begin
                     sp_ff <= sp_ff + CNT_BITS'(1);
                  end
                  state_ff <= ST_PUSH2;
               end else begin
                  state_ff <= ST_POP;
               end
            end
            ST_PUSH2: begin
               if (stk_wr) begin
                  sp_ff <= sp_ff + CNT_BITS'(1);
               end
               state_ff <= ST_POP;
            end
            ST_EMIT: begin
               if (emit_load) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_idx_ff   <= em_ff;
                  rsp_keep_ff  <= kp_rd_data;
                  rsp_ovf_ff   <= ovf_ff;
                  rsp_last_ff  <= (em_ff == last_idx);
                  if (em_ff == last_idx) begin
                     count_ff <= '0;
                     ovf_ff   <= 1'b0;
                     state_ff <= ST_IDLE;
                  end else begin
                     em_ff <= em_ff + IDX_BITS'(1);
                  end
               end
            end
         endcase
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = rsp_idx_ff;
   assign rsp_keep        = rsp_keep_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_last        = rsp_last_ff;
   assign csr_pready      = 1'b1;

   always_comb begin
      unique case (csr_paddr[2])
         CSR_EPSILON:    csr_prdata = CSR_BITS'(eps_ff);
         CSR_THREE_DIMS: csr_prdata = CSR_BITS'(dims_ff);
      endcase
   end

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CNT_BITS'(MAX_POINTS))
      else $error("segment stack depth beyond capacity");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(MAX_POINTS))
      else $error("point count beyond capacity");

   a_interior: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (i_ff > si_ff) && (i_ff < li_ff))
      else $error("scanned point outside the open segment");

   a_ends_kept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && emit_load && (em_ff == '0 || em_ff == last_idx)) |-> kp_rd_data)
      else $error("end points of polyline not kept");

   a_no_stall_loss: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && rsp_stall) |=> $stable(em_ff))
      else $error("mask item advanced while output stalled");

endmodule
